[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds in the same cycle
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/pifenc_pkg.sv]
`timescale 1ns / 1ps

package pifenc_pkg;

	localparam logic [2:0] OP_RAW    = 3'd0;
	localparam logic [2:0] OP_CONS   = 3'd1;
	localparam logic [2:0] OP_SEMI   = 3'd2;
	localparam logic [2:0] OP_UNCONS = 3'd3;
	localparam logic [2:0] OP_FLUSH  = 3'd4;

	localparam int unsigned SDATA_W = 208;
	localparam int unsigned BITS_W  = 72;
	localparam int unsigned SHIFT_W = 80;

	typedef struct packed {
		logic                flush;
		logic [6:0]          nbits;
		logic [BITS_W-1:0]   bits;   // left-aligned, zeros below nbits
	} q_entry_t;

	typedef struct packed {
		logic [7:0] partial;
		logic [2:0] fill;
	} back_status_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_CLAMP,
		F_OFFS,
		F_SIZE,
		F_BUILD,
		F_PUSH
	} front_state_t;

	typedef enum logic {
		B_IDLE,
		B_EMIT
	} back_state_t;

	// number of significant bits in a byte
	function automatic logic [3:0] bit_len8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				n = 4'(i + 1);
		end
		return n;
	endfunction

endpackage

[rtl/core/pifenc_front.sv]
`timescale 1ns / 1ps

module pifenc_front #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [pifenc_pkg::SDATA_W-1:0]    s_tdata,
	input  logic                              full,
	output logic                              push,
	output pifenc_pkg::q_entry_t              entry
);
	import pifenc_pkg::*;

	localparam int SH       = 64 - VALUE_WIDTH;
	localparam int MAXN_RAW = (VALUE_WIDTH + 7) / 8;
	localparam int MAXN     = (MAXN_RAW > 8) ? 8 : MAXN_RAW;

	front_state_t state_q, state_d;

	logic [2:0]        op_q;
	logic [63:0]       raw_q;
	logic [6:0]        cnt_q;
	logic [63:0]       v_q, lo_q, hi_q;
	logic              skip_q;
	logic [63:0]       off_q, range_q;
	logic [2:0]        hb_idx_q;
	logic [7:0]        hb_byte_q;
	logic              hb_any_q;
	logic [3:0]        nb_q;
	logic [BITS_W-1:0] bits_q;
	logic [6:0]        nbits_q;
	logic              push_q;

	logic              accept;
	logic              lt_vlo, lt_hiv, le_hilo;
	logic [63:0]       v_clamp;
	logic [63:0]       src;
	logic [2:0]        hb_idx;
	logic [7:0]        hb_byte;
	logic              hb_any;
	logic [3:0]        nb_sint;
	logic [3:0]        nb_uint;
	logic [6:0]        len_sh;
	logic [BITS_W-1:0] len_word;
	logic [63:0]       low_mask;
	logic [BITS_W-1:0] bits_b;
	logic [6:0]        nbits_b;
	logic              push_b;

	function automatic logic [63:0] sext(input logic [63:0] x);
		logic [63:0] t;
		t = x << SH;
		return 64'($signed(t) >>> SH);
	endfunction

	assign accept = s_tvalid && s_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE:  if (accept) state_d = F_CLAMP;
			F_CLAMP: state_d = F_OFFS;
			F_OFFS:  state_d = F_SIZE;
			F_SIZE:  state_d = F_BUILD;
			F_BUILD: state_d = F_PUSH;
			F_PUSH:  if (!push_q || !full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready    = 1'b0;
		push        = 1'b0;
		entry.flush = (op_q == OP_FLUSH);
		entry.nbits = nbits_q;
		entry.bits  = bits_q << (7'd72 - nbits_q);
		case (state_q)
			F_IDLE:  s_tready = 1'b1;
			F_PUSH:  push = push_q && !full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// saturation to the bounds: both for OP_CONS, the lower one only for OP_SEMI
	always_comb begin
		lt_vlo  = $signed(v_q) < $signed(lo_q);
		lt_hiv  = $signed(hi_q) < $signed(v_q);
		le_hilo = $signed(hi_q) <= $signed(lo_q);
		v_clamp = v_q;
		if ((op_q == OP_CONS) || (op_q == OP_SEMI)) begin
			if (lt_vlo)
				v_clamp = lo_q;
			else if ((op_q == OP_CONS) && lt_hiv)
				v_clamp = hi_q;
		end
	end

	// byte sizing: highest nonzero byte, minimal unsigned and signed byte counts
	always_comb begin
		src     = (op_q == OP_CONS) ? range_q : off_q;
		hb_idx  = 3'd0;
		hb_byte = 8'd0;
		hb_any  = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (|src[8*i +: 8]) begin
				hb_idx  = 3'(i);
				hb_byte = src[8*i +: 8];
				hb_any  = 1'b1;
			end
		end
		nb_uint = hb_any ? ({1'b0, hb_idx} + 4'd1) : 4'd1;
		nb_sint = 4'(MAXN);
		for (int n = 7; n >= 1; n--) begin
			if (n < MAXN) begin
				if (((v_q >> (8*n - 1)) == 64'd0) ||
				    ((v_q >> (8*n - 1)) == (64'hFFFF_FFFF_FFFF_FFFF >> (8*n - 1))))
					nb_sint = 4'(n);
			end
		end
	end

	// bit string and length for the queue
	always_comb begin
		len_sh   = {nb_q, 3'b000};
		len_word = {64'd0, 4'd0, nb_q} << len_sh;
		low_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << len_sh);
		bits_b   = '0;
		nbits_b  = 7'd0;
		push_b   = 1'b0;
		case (op_q)
			OP_RAW: begin
				bits_b  = {8'd0, raw_q};
				nbits_b = (cnt_q > 7'd64) ? 7'd64 : cnt_q;
				push_b  = 1'b1;
			end
			OP_CONS: begin
				bits_b  = {8'd0, off_q};
				nbits_b = {1'b0, hb_idx_q, 3'b000} + {3'd0, bit_len8(hb_byte_q)};
				push_b  = !skip_q && hb_any_q;
			end
			OP_SEMI: begin
				bits_b  = len_word | {8'd0, off_q & low_mask};
				nbits_b = len_sh + 7'd8;
				push_b  = 1'b1;
			end
			OP_UNCONS: begin
				bits_b  = len_word | {8'd0, v_q & low_mask};
				nbits_b = len_sh + 7'd8;
				push_b  = 1'b1;
			end
			OP_FLUSH: push_b = 1'b1;
			default: push_b = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: if (accept) begin
				op_q  <= s_tdata[2:0];
				raw_q <= s_tdata[66:3];
				v_q   <= sext(s_tdata[66:3]);
				lo_q  <= sext(s_tdata[130:67]);
				hi_q  <= sext(s_tdata[194:131]);
				cnt_q <= s_tdata[201:195];
			end
			F_CLAMP: begin
				v_q    <= v_clamp;
				skip_q <= le_hilo;
			end
			F_OFFS: begin
				off_q   <= v_q - lo_q;
				range_q <= hi_q - lo_q;
			end
			F_SIZE: begin
				hb_idx_q  <= hb_idx;
				hb_byte_q <= hb_byte;
				hb_any_q  <= hb_any;
				nb_q      <= (op_q == OP_UNCONS) ? nb_sint : nb_uint;
			end
			F_BUILD: begin
				bits_q  <= bits_b;
				nbits_q <= nbits_b;
				push_q  <= push_b;
			end
			default: ;
		endcase
	end

endmodule

[rtl/core/pifenc_queue.sv]
`timescale 1ns / 1ps

module pifenc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pifenc_pkg::q_entry_t  entry_in,
	input  logic                  pop,
	output pifenc_pkg::q_entry_t  entry_out,
	output logic                  full,
	output logic                  empty
);
	import pifenc_pkg::*;

	q_entry_t   slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign empty     = (cnt_q == 2'd0);
	assign entry_out = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= entry_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

[rtl/core/pifenc_back.sv]
`timescale 1ns / 1ps

module pifenc_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      empty,
	input  pifenc_pkg::q_entry_t      entry,
	output logic                      pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,   // out_byte
	output logic                      m_tlast,
	output pifenc_pkg::back_status_t  status
);
	import pifenc_pkg::*;

	localparam logic [6:0] BYTE_BITS = 7'd8;

	back_state_t state_q, state_d;

	logic [SHIFT_W-1:0] sh_q;
	logic [6:0]         tot_q;
	logic [7:0]         partial_q;
	logic [2:0]         fill_q;
	logic               ov_q;
	logic [7:0]         ob_q;
	logic               ol_q;

	logic               slot_free;
	logic               emit;
	logic               done;
	logic [SHIFT_W-1:0] sh_load;
	logic [6:0]         tot_load;

	assign slot_free = !ov_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:  if (!empty) state_d = B_EMIT;
			B_EMIT:  if (tot_q < BYTE_BITS) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop  = 1'b0;
		emit = 1'b0;
		done = 1'b0;
		case (state_q)
			B_IDLE: pop = !empty;
			B_EMIT: begin
				emit = (tot_q >= BYTE_BITS) && slot_free;
				done = (tot_q < BYTE_BITS);
			end
			default: ;
		endcase
	end

	// merge pending bits with the new string; flush pushes the partial byte out alone
	always_comb begin
		if (entry.flush) begin
			sh_load  = {partial_q, 72'd0};
			tot_load = (fill_q != 3'd0) ? BYTE_BITS : 7'd0;
		end else begin
			sh_load  = {partial_q, 72'd0} | ({entry.bits, 8'd0} >> fill_q);
			tot_load = {4'd0, fill_q} + entry.nbits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			partial_q <= 8'd0;
			fill_q    <= 3'd0;
			ov_q      <= 1'b0;
			tot_q     <= 7'd0;
		end else begin
			state_q <= state_d;
			if (pop)
				tot_q <= tot_load;
			else if (emit)
				tot_q <= tot_q - BYTE_BITS;
			if (done) begin
				partial_q <= sh_q[SHIFT_W-1 -: 8];
				fill_q    <= tot_q[2:0];
			end
			if (emit)
				ov_q <= 1'b1;
			else if (m_tready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			sh_q <= sh_load;
		else if (emit)
			sh_q <= sh_q << 8;
		if (emit) begin
			ob_q <= sh_q[SHIFT_W-1 -: 8];
			ol_q <= (tot_q < 7'd16);
		end
	end

	assign m_tvalid       = ov_q;
	assign m_tdata        = ob_q;
	assign m_tlast        = ol_q;
	assign status.partial = partial_q;
	assign status.fill    = fill_q;

endmodule

[rtl/core/per_integer_field_encoder_core.sv]
// the front steps each value through clamp, offset, size, build and push states and takes
// a new value only in its idle state; a two-entry queue lets both halves overlap
// the back merges pending bits and emits one byte per cycle while m_tready is high
// reset: arst_n clears the sequencers, the queue and the output valid at once,
// and empties the partial byte and its bit count
`timescale 1ns / 1ps
`include "assert_macros.svh"

module per_integer_field_encoder_core #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// op[2:0], value[66:3], lower[130:67], upper[194:131], bit_count[201:195], zero fill
	input  logic [pifenc_pkg::SDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_byte[7:0]
	output logic [7:0]                      m_tdata,
	output logic                            m_tlast
);
	import pifenc_pkg::*;

	q_entry_t     q_in, q_out;
	logic         q_push, q_pop, q_full, q_empty;
	back_status_t b_status;
	logic [7:0]   stray_bits;

	pifenc_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.full     (q_full),
		.push     (q_push),
		.entry    (q_in)
	);

	pifenc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.entry_in  (q_in),
		.pop       (q_pop),
		.entry_out (q_out),
		.full      (q_full),
		.empty     (q_empty)
	);

	pifenc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.entry    (q_out),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.status   (b_status)
	);

	// bits of the partial byte below its fill point
	assign stray_bits = b_status.partial & (8'hFF >> b_status.fill);

	`ASSERT_AT(a_no_push_full, clk, arst_n, !(q_push && q_full), "push into full queue")
	`ASSERT_AT(a_no_pop_empty, clk, arst_n, !(q_pop && q_empty), "pop from empty queue")
	`ASSERT_AT(a_partial_clean, clk, arst_n, stray_bits == 8'h00, "stray bits below fill")
	`ASSERT_NEXT(a_queue_fills, clk, arst_n, q_push && !q_pop && !q_empty, q_full, "queue count lost")

endmodule
